[rtl/assert_macros.svh]
// Assertion macros used by the rank selection datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define KSS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("kss assertion failed");

// Implication checked at every clock edge outside reset.
`define KSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kss assertion failed");

`else

`define KSS_ASSERT(label, prop)
`define KSS_ASSERT_IMP(label, ante, cons)

`endif

`endif

[rtl/kss_pkg.sv]
// Types, constants and the microcode program of the rank selection block.
`timescale 1ns / 1ps

package kss_pkg;

    localparam int KEY_W     = 32;
    localparam int RANK_W    = 10;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;
    localparam int PC_W      = 4;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_START,
        OP_PIVOT,
        OP_CLASS,
        OP_STEP,
        OP_NARROW,
        OP_RESULT
    } op_t;

    // Key store read address selection.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_HI,
        RD_I,
        RD_PART,
        RD_ABOVE,
        RD_WANT
    } rd_sel_t;

    // Key store write selection.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_I,
        WR_PART,
        WR_HI,
        WR_ABOVE
    } wr_sel_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST,
        C_LO_GE_HI,
        C_I_GE_ABOVE,
        C_KEY_EQ,
        C_FOUND,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        rd_sel_t          rd;
        wr_sel_t          wr;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    // Flags the datapath reports to the sequencer.
    typedef struct packed {
        logic lo_ge_hi;
        logic i_ge_above;
        logic key_eq;
        logic found;
    } kss_status_t;

    // Program step addresses.
    localparam logic [PC_W-1:0] ST_LOAD    = PC_W'(0);
    localparam logic [PC_W-1:0] ST_SETUP   = PC_W'(1);
    localparam logic [PC_W-1:0] ST_OUTER   = PC_W'(2);
    localparam logic [PC_W-1:0] ST_PIVOT   = PC_W'(3);
    localparam logic [PC_W-1:0] ST_SCAN    = PC_W'(4);
    localparam logic [PC_W-1:0] ST_CLASS   = PC_W'(5);
    localparam logic [PC_W-1:0] ST_SWAP_A  = PC_W'(6);
    localparam logic [PC_W-1:0] ST_SWAP_B  = PC_W'(7);
    localparam logic [PC_W-1:0] ST_PLACE   = PC_W'(8);
    localparam logic [PC_W-1:0] ST_PLACE_A = PC_W'(9);
    localparam logic [PC_W-1:0] ST_PLACE_B = PC_W'(10);
    localparam logic [PC_W-1:0] ST_LOOP    = PC_W'(11);
    localparam logic [PC_W-1:0] ST_FIN     = PC_W'(12);
    localparam logic [PC_W-1:0] ST_RESULT  = PC_W'(13);
    localparam logic [PC_W-1:0] ST_DONE    = PC_W'(14);

    // Microcode ROM. A step jumps to its target when its condition holds,
    // otherwise it falls through to the next step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            ST_LOAD:    w = '{op: OP_LOAD,   rd: RD_NONE,  wr: WR_LOAD,  cond: C_NOT_LAST,
                              target: ST_LOAD};
            ST_SETUP:   w = '{op: OP_SETUP,  rd: RD_NONE,  wr: WR_NONE,  cond: C_NEVER,
                              target: ST_LOAD};
            ST_OUTER:   w = '{op: OP_START,  rd: RD_HI,    wr: WR_NONE,  cond: C_LO_GE_HI,
                              target: ST_FIN};
            ST_PIVOT:   w = '{op: OP_PIVOT,  rd: RD_NONE,  wr: WR_NONE,  cond: C_NEVER,
                              target: ST_LOAD};
            ST_SCAN:    w = '{op: OP_NONE,   rd: RD_I,     wr: WR_NONE,  cond: C_I_GE_ABOVE,
                              target: ST_PLACE};
            ST_CLASS:   w = '{op: OP_CLASS,  rd: RD_PART,  wr: WR_NONE,  cond: C_KEY_EQ,
                              target: ST_SCAN};
            ST_SWAP_A:  w = '{op: OP_NONE,   rd: RD_NONE,  wr: WR_I,     cond: C_NEVER,
                              target: ST_LOAD};
            ST_SWAP_B:  w = '{op: OP_STEP,   rd: RD_NONE,  wr: WR_PART,  cond: C_ALWAYS,
                              target: ST_SCAN};
            ST_PLACE:   w = '{op: OP_NONE,   rd: RD_ABOVE, wr: WR_NONE,  cond: C_NEVER,
                              target: ST_LOAD};
            ST_PLACE_A: w = '{op: OP_NONE,   rd: RD_NONE,  wr: WR_HI,    cond: C_NEVER,
                              target: ST_LOAD};
            ST_PLACE_B: w = '{op: OP_NARROW, rd: RD_NONE,  wr: WR_ABOVE, cond: C_FOUND,
                              target: ST_FIN};
            ST_LOOP:    w = '{op: OP_NONE,   rd: RD_NONE,  wr: WR_NONE,  cond: C_ALWAYS,
                              target: ST_OUTER};
            ST_FIN:     w = '{op: OP_NONE,   rd: RD_WANT,  wr: WR_NONE,  cond: C_NEVER,
                              target: ST_LOAD};
            ST_RESULT:  w = '{op: OP_RESULT, rd: RD_NONE,  wr: WR_NONE,  cond: C_OUT_BUSY,
                              target: ST_RESULT};
            ST_DONE:    w = '{op: OP_NONE,   rd: RD_NONE,  wr: WR_NONE,  cond: C_ALWAYS,
                              target: ST_LOAD};
            default:    w = '{op: OP_NONE,   rd: RD_NONE,  wr: WR_NONE,  cond: C_ALWAYS,
                              target: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

[rtl/kss_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/kss_seq.sv]
// Microcode sequencer: step counter, program ROM and jump logic.
`timescale 1ns / 1ps

module kss_seq
    import kss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  kss_status_t status,
    input  logic        beat_last,
    input  logic        out_busy,
    output ctrl_word_t  ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = ucode(pc_reg);

    // Evaluate the jump condition of the current step.
    always_comb begin
        case (ctrl.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NOT_LAST:   take = !beat_last;
            C_LO_GE_HI:   take = status.lo_ge_hi;
            C_I_GE_ABOVE: take = status.i_ge_above;
            C_KEY_EQ:     take = status.key_eq;
            C_FOUND:      take = status.found;
            C_OUT_BUSY:   take = out_busy;
            default:      take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + PC_W'(1);
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/kss_datapath.sv]
// Partition datapath: range pointers, pivot, key store and its addressing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kss_datapath
    import kss_pkg::*;
#(
    parameter int MAX_KEYS = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_word_t        ctrl,
    input  logic              s_beat,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [RANK_W-1:0] s_rank,
    output kss_status_t       status,
    output logic [KEY_W-1:0]  result_key,
    output logic              result_clamped
);

    localparam int IW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int CMP_W = (CW > RANK_W) ? CW : RANK_W;

    logic [CW-1:0]     count_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [IW-1:0]     lo_reg;
    logic [IW-1:0]     hi_reg;
    logic [IW-1:0]     want_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     lt_reg;
    logic [IW-1:0]     above_reg;
    logic [KEY_W-1:0]  pv_reg;
    logic [KEY_W-1:0]  vi_reg;
    logic              dir_reg;
    logic              clamped_reg;

    logic              store_full;
    logic              key_lt;
    logic [IW-1:0]     above_m1;
    logic [CMP_W-1:0]  rank_ext;
    logic [CMP_W-1:0]  count_ext;
    logic              rank_over;

    logic              ram_wr_en;
    logic [IW-1:0]     ram_wr_addr;
    logic [KEY_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [IW-1:0]     ram_rd_addr;
    logic [KEY_W-1:0]  ram_rd_data;

    assign store_full = (count_reg >= CW'(MAX_KEYS));
    assign key_lt     = (ram_rd_data < pv_reg);
    assign above_m1   = above_reg - IW'(1);
    assign rank_ext   = CMP_W'(rank_reg);
    assign count_ext  = CMP_W'(count_reg);
    assign rank_over  = (rank_ext >= count_ext);

    // Flags for the sequencer's jumps.
    always_comb begin
        status.lo_ge_hi   = (lo_reg >= hi_reg);
        status.i_ge_above = (i_reg >= above_reg);
        status.key_eq     = (ram_rd_data == pv_reg);
        status.found      = (lt_reg <= want_reg) && (want_reg <= above_reg);
    end

    assign result_key     = ram_rd_data;
    assign result_clamped = clamped_reg;

    // Key store read address.
    always_comb begin
        ram_rd_en = 1'b1;
        case (ctrl.rd)
            RD_HI:    ram_rd_addr = hi_reg;
            RD_I:     ram_rd_addr = i_reg;
            RD_PART:  ram_rd_addr = key_lt ? lt_reg : above_m1;
            RD_ABOVE: ram_rd_addr = above_reg;
            RD_WANT:  ram_rd_addr = want_reg;
            default: begin
                ram_rd_en   = 1'b0;
                ram_rd_addr = '0;
            end
        endcase
    end

    // Key store write address and data.
    always_comb begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = ram_rd_data;
        case (ctrl.wr)
            WR_LOAD: begin
                ram_wr_en   = s_beat && !store_full;
                ram_wr_addr = count_reg[IW-1:0];
                ram_wr_data = s_key;
            end
            WR_I: begin
                ram_wr_addr = i_reg;
            end
            WR_PART: begin
                ram_wr_addr = dir_reg ? lt_reg : above_m1;
                ram_wr_data = vi_reg;
            end
            WR_HI: begin
                ram_wr_addr = hi_reg;
            end
            WR_ABOVE: begin
                ram_wr_addr = above_reg;
                ram_wr_data = pv_reg;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    kss_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Key count is the only control state here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.op == OP_LOAD && s_beat && !store_full) begin
            count_reg <= count_reg + CW'(1);
        end else if (ctrl.op == OP_SETUP) begin
            count_reg <= '0;
        end
    end

    // Range pointers, pivot and the key under test.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                if (s_beat) begin
                    rank_reg <= s_rank;
                end
            end
            OP_SETUP: begin
                lo_reg      <= '0;
                hi_reg      <= IW'(count_reg - CW'(1));
                clamped_reg <= rank_over;
                want_reg    <= rank_over ? IW'(count_reg - CW'(1)) : IW'(rank_ext);
            end
            OP_START: begin
                i_reg     <= lo_reg;
                lt_reg    <= lo_reg;
                above_reg <= hi_reg;
            end
            OP_PIVOT: begin
                pv_reg <= ram_rd_data;
            end
            OP_CLASS: begin
                vi_reg  <= ram_rd_data;
                dir_reg <= key_lt;
                if (status.key_eq) begin
                    i_reg <= i_reg + IW'(1);
                end
            end
            OP_STEP: begin
                // A smaller key joins the lower part, a larger one the upper part.
                if (dir_reg) begin
                    lt_reg <= lt_reg + IW'(1);
                    i_reg  <= i_reg + IW'(1);
                end else begin
                    above_reg <= above_m1;
                end
            end
            OP_NARROW: begin
                if (!status.found) begin
                    if (want_reg < lt_reg) begin
                        hi_reg <= lt_reg - IW'(1);
                    end else begin
                        lo_reg <= above_reg + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `KSS_ASSERT(a_count_bound, count_reg <= CW'(MAX_KEYS))
    `KSS_ASSERT_IMP(a_scan_order, ctrl.op == OP_CLASS, (lt_reg <= i_reg) && (i_reg < above_reg))
    `KSS_ASSERT_IMP(a_want_in_range, ctrl.op == OP_NARROW, (lo_reg <= want_reg) && (want_reg <= hi_reg))
    `KSS_ASSERT_IMP(a_above_in_range, ctrl.op == OP_NARROW, (lo_reg <= above_reg) && (above_reg <= hi_reg))

endmodule

[rtl/kth_smallest_select.sv]
// Top level of the k-th smallest key selector.
//
// Usage: keys stream in on the s_axis channel, one beat per key, stored in
// arrival order; the beat with s_axis_tlast high ends the set and carries the
// wanted zero-based rank. The block then runs quickselect (last element as
// pivot, three-way partition) on the stored keys and returns one beat on
// m_axis: the key of that rank and a flag set when the rank was at or beyond
// the key count and was clamped to count-1. Keys beyond MAX_KEYS are dropped.
// Keys load at one beat per cycle while the block is in its load step; no key
// is taken while a set is being processed. After the last beat, partition
// passes shrink the range as in quickselect until the rank is found; the key
// store has one read port and one write port.
// Reset clears the sequencer, key count and output valid; no clearing pass
// runs, as only written entries are read. A stalled m_axis holds its beat;
// the next set may load meanwhile, and its result waits until the beat is taken.
`timescale 1ns / 1ps

module kth_smallest_select
    import kss_pkg::*;
#(
    parameter int MAX_KEYS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key[31:0], target_rank[41:32], zero pad
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // selected_key[31:0]
    output logic                 m_axis_tuser    // rank_clamped[0]
);

    ctrl_word_t       ctrl;
    kss_status_t      status;
    logic             s_beat;
    logic             beat_last;
    logic             out_busy;
    logic             out_load;
    logic [KEY_W-1:0] result_key;
    logic             result_clamped;

    logic             m_valid_reg;
    logic [KEY_W-1:0] m_data_reg;
    logic             m_user_reg;

    // Input handshake: keys are taken only in the load step.
    assign s_axis_tready = (ctrl.op == OP_LOAD);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign beat_last     = s_beat && s_axis_tlast;

    // Output register frees up when its beat is taken.
    assign out_busy = m_valid_reg && !m_axis_tready;
    assign out_load = (ctrl.op == OP_RESULT) && !out_busy;

    kss_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .status    (status),
        .beat_last (beat_last),
        .out_busy  (out_busy),
        .ctrl      (ctrl)
    );

    kss_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .s_beat         (s_beat),
        .s_key          (s_axis_tdata[KEY_W-1:0]),
        .s_rank         (s_axis_tdata[KEY_W +: RANK_W]),
        .status         (status),
        .result_key     (result_key),
        .result_clamped (result_clamped)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result_key;
            m_user_reg <= result_clamped;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_data_reg);
    assign m_axis_tuser  = m_user_reg;

endmodule

[dv/kth_smallest_select_test.sv]
// Self-checking testbench for the k-th smallest key selector.
`timescale 1ns / 1ps

module kth_smallest_select_test;
    import kss_pkg::*;

    localparam int MAX_KEYS   = 1024;
    localparam int CYCLE_CAP  = 1000000;
    localparam int PHASE_KEYS = 175;

    // One key beat as it is sent on the input channel.
    typedef struct {
        logic [KEY_W-1:0]  key;
        logic              last;
        logic [RANK_W-1:0] rank;
    } key_beat_t;

    // One result beat as it should appear on the output channel.
    typedef struct {
        logic [KEY_W-1:0] selected_key;
        logic             rank_clamped;
    } pick_t;

    // Kinds of key sets that the random part draws from.
    typedef enum int {
        SHAPE_SCATTER,
        SHAPE_REPEAT,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_EXTREME
    } set_shape_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // key[31:0], target_rank[41:32], zero pad
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // selected_key[31:0]
    logic                 m_axis_tuser;        // rank_clamped[0]

    key_beat_t        key_beats[$];
    key_beat_t        next_beat;
    pick_t            expected_picks[$];
    pick_t            oldest_pick;
    pick_t            new_pick;
    logic [KEY_W-1:0] set_keys[MAX_KEYS];
    int               set_count = 0;
    int               want_rank;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               idle_plan[4] = '{0, 66, 0, 9};
    int               stall_plan[4] = '{0, 0, 66, 9};

    kth_smallest_select #(
        .MAX_KEYS(MAX_KEYS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // Exchange two entries of the predicted key store.
    function automatic void swap_keys(input int a, input int b);
        logic [KEY_W-1:0] t;
        t = set_keys[a];
        set_keys[a] = set_keys[b];
        set_keys[b] = t;
    endfunction

    // Quickselect over the first n stored keys: last element as pivot, three-way
    // partition into less, equal and greater parts, narrowing until the wanted
    // rank falls into the equal block.
    function automatic logic [KEY_W-1:0] pick_kth(input int n, input int want);
        int               lo;
        int               hi;
        int               below;
        int               above;
        int               i;
        logic             found;
        logic [KEY_W-1:0] pv;
        lo = 0;
        hi = n - 1;
        found = 1'b0;
        while (lo < hi && !found) begin
            pv = set_keys[hi];
            below = lo - 1;
            above = hi;
            i = lo;
            while (i < above) begin
                if (set_keys[i] < pv) begin
                    below++;
                    swap_keys(i, below);
                    i++;
                end else if (set_keys[i] > pv) begin
                    above--;
                    swap_keys(i, above);
                end else begin
                    i++;
                end
            end
            swap_keys(hi, above);
            if (below < want && want <= above) begin
                found = 1'b1;
            end else if (want <= below) begin
                hi = below;
            end else begin
                lo = above + 1;
            end
        end
        return set_keys[want];
    endfunction

    task automatic push_beat(input logic [KEY_W-1:0] key, input logic last,
                             input logic [RANK_W-1:0] rank);
        key_beat_t b;
        b.key = key;
        b.last = last;
        b.rank = rank;
        key_beats.push_back(b);
    endtask

    // Queue a set of n keys of a random shape; the rank is mostly in range.
    task automatic queue_random_set(input int n);
        set_shape_t        shape;
        logic [KEY_W-1:0]  pool[4];
        logic [KEY_W-1:0]  k;
        logic [RANK_W-1:0] want;
        shape = set_shape_t'($urandom_range(4));
        foreach (pool[j]) pool[j] = $urandom;
        if (shape == SHAPE_FALLING) begin
            k = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
        end else begin
            k = $urandom_range(0, 1 << 20);
        end
        if ($urandom_range(3) != 0) begin
            want = RANK_W'($urandom_range(n - 1));
        end else begin
            want = RANK_W'($urandom_range(1023));
        end
        for (int j = 0; j < n; j++) begin
            case (shape)
                SHAPE_SCATTER: k = $urandom;
                SHAPE_REPEAT:  k = pool[$urandom_range(3)];
                SHAPE_RISING:  k = k + $urandom_range(0, 1 << 16);
                SHAPE_FALLING: k = k - $urandom_range(0, 1 << 16);
                default:       k = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            push_beat(k, j == n - 1, (j == n - 1) ? want : RANK_W'($urandom_range(1023)));
        end
    endtask

    // Wait until every queued beat is sent and every expected result is back.
    task automatic wait_until_drained();
        while (key_beats.size() != 0 || s_axis_tvalid || expected_picks.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: present the next pending key beat once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (key_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_beat = key_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= S_TDATA_W'({next_beat.rank, next_beat.key});
                s_axis_tlast <= next_beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: check each result beat, then predict from each accepted key beat.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected result beat: selected_key %h, rank_clamped %b",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                oldest_pick = expected_picks.pop_front();
                if (m_axis_tdata !== oldest_pick.selected_key) begin
                    $error("selected_key: expected %h, got %h",
                           oldest_pick.selected_key, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== oldest_pick.rank_clamped) begin
                    $error("rank_clamped: expected %b, got %b",
                           oldest_pick.rank_clamped, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            // Keys beyond the store size are dropped, the last one included.
            if (set_count < MAX_KEYS) begin
                set_keys[set_count] = s_axis_tdata[KEY_W-1:0];
                set_count++;
            end
            if (s_axis_tlast) begin
                want_rank = int'(s_axis_tdata[KEY_W +: RANK_W]);
                new_pick.rank_clamped = 1'b0;
                if (want_rank >= set_count) begin
                    want_rank = set_count - 1;
                    new_pick.rank_clamped = 1'b1;
                end
                new_pick.selected_key = pick_kth(set_count, want_rank);
                expected_picks.push_back(new_pick);
                set_count = 0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[kth_smallest_select] ERROR");
            $finish;
        end
    end

    // Stimulus: directed sets, a set that overfills the store, then random
    // sets under each idling pattern.
    initial begin : stimulus
        int pushed;
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            @(negedge aclk);
            send_idle_pct = idle_plan[p];
            stall_pct = stall_plan[p];
            if (p == 0) begin
                // Single key, smallest value, rank in range.
                push_beat(32'h0, 1'b1, 10'd0);
                // Single key, largest value, largest rank gets clamped.
                push_beat(32'hFFFF_FFFF, 1'b1, 10'd1023);
                // Two extremes in both orders.
                push_beat(32'hFFFF_FFFF, 1'b0, 10'd0);
                push_beat(32'h0, 1'b1, 10'd0);
                push_beat(32'h0, 1'b0, 10'd0);
                push_beat(32'hFFFF_FFFF, 1'b1, 10'd1);
                // All keys equal to the pivot.
                repeat (3) push_beat(32'd7, 1'b0, 10'd0);
                push_beat(32'd7, 1'b1, 10'd2);
                // Already sorted ascending, highest rank.
                for (int j = 1; j <= 5; j++) push_beat(32'(j), j == 5, 10'd4);
                // Sorted descending, lowest rank.
                for (int j = 5; j >= 1; j--) push_beat(32'(j), j == 1, 10'd0);
                // Repeated pivot value; rank equal to the count is clamped.
                push_beat(32'd5, 1'b0, 10'd0);
                push_beat(32'd9, 1'b0, 10'd0);
                push_beat(32'd5, 1'b0, 10'd0);
                push_beat(32'd1, 1'b0, 10'd0);
                push_beat(32'd5, 1'b1, 10'd5);
                wait_until_drained();
                // Overfilled store: the last two keys are dropped.
                for (int j = 0; j < MAX_KEYS + 2; j++)
                    push_beat($urandom, j == MAX_KEYS + 1, 10'd1023);
                wait_until_drained();
            end
            pushed = 0;
            while (pushed < PHASE_KEYS) begin
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(13, 40);
                end else begin
                    n = $urandom_range(1, 12);
                end
                queue_random_set(n);
                pushed += n;
            end
            wait_until_drained();
        end
        repeat (50) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("[kth_smallest_select] OK");
        end else begin
            $display("[kth_smallest_select] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/kss_pkg.sv
rtl/kss_ram.sv
rtl/kss_seq.sv
rtl/kss_datapath.sv
rtl/kth_smallest_select.sv
dv/kth_smallest_select_test.sv
